// ===== rtl/msp_pkg.sv =====
`default_nettype none

package msp_pkg;

  // Payload store geometry
  localparam int unsigned MaxPayload = 64;
  localparam int unsigned AddrW      = $clog2(MaxPayload);
  localparam int unsigned LenW       = 7;
  localparam int unsigned ByteW      = 8;

  // Frame header bytes
  localparam logic [ByteW-1:0] SyncDollar = 8'h24;
  localparam logic [ByteW-1:0] SyncM      = 8'h4D;
  localparam logic [ByteW-1:0] SyncLt     = 8'h3C;

  // Size limit after reset
  localparam logic [LenW-1:0] LimitReset = LenW'(MaxPayload);

  // Request from the parser to the emitter
  typedef struct packed {
    logic             start;
    logic [ByteW-1:0] command;
    logic [LenW-1:0]  length;
  } emit_req_t;

endpackage

`default_nettype wire

// ===== rtl/msp_ram.sv =====
`default_nettype none

module msp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/msp_parse.sv =====
`default_nettype none

module msp_parse (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [7:0]                rx_byte_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [6:0]                cfg_data_i,
  output logic                           we_o,
  output logic      [msp_pkg::AddrW-1:0] waddr_o,
  output logic      [7:0]                wdata_o,
  output msp_pkg::emit_req_t             req_o
);

  import msp_pkg::*;

  localparam logic [2:0] PsIdle   = 3'd0;
  localparam logic [2:0] PsDollar = 3'd1;
  localparam logic [2:0] PsM      = 3'd2;
  localparam logic [2:0] PsArrow  = 3'd3;
  localparam logic [2:0] PsLen    = 3'd4;
  localparam logic [2:0] PsBody   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [LenW-1:0]  exp_len_q, exp_len_d;
  logic [LenW-1:0]  fill_q, fill_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [LenW-1:0]  limit_q;
  logic [LenW-1:0]  limit_eff;

  // Saturate the limit to the store depth
  assign limit_eff = (limit_q > LenW'(MaxPayload)) ? LenW'(MaxPayload) : limit_q;

  // Advance the parser on each accepted byte
  always_comb begin
    state_d   = state_q;
    exp_len_d = exp_len_q;
    fill_d    = fill_q;
    xor_d     = xor_q;
    cmd_d     = cmd_q;
    we_o      = 1'b0;
    req_o     = '{start: 1'b0, command: cmd_q, length: exp_len_q};
    if (accept_i) begin
      case (state_q)
        PsDollar: state_d = (rx_byte_i == SyncM) ? PsM : PsIdle;
        PsM:      state_d = (rx_byte_i == SyncLt) ? PsArrow : PsIdle;
        PsArrow: begin
          if (rx_byte_i > {1'b0, limit_eff}) begin
            state_d = PsIdle;
          end else begin
            exp_len_d = rx_byte_i[LenW-1:0];
            xor_d     = rx_byte_i;
            fill_d    = '0;
            state_d   = PsLen;
          end
        end
        PsLen: begin
          cmd_d   = rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          state_d = PsBody;
        end
        PsBody: begin
          if (fill_q < exp_len_q) begin
            xor_d  = xor_q ^ rx_byte_i;
            we_o   = 1'b1;
            fill_d = fill_q + LenW'(1);
          end else begin
            // Hand a good frame over to the emitter, drop a bad one
            req_o.start = (xor_q == rx_byte_i);
            state_d     = PsIdle;
          end
        end
        default: state_d = (rx_byte_i == SyncDollar) ? PsDollar : PsIdle;
      endcase
    end
  end

  assign waddr_o = fill_q[AddrW-1:0];
  assign wdata_o = rx_byte_i;

  // Hold parser state and size limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= PsIdle;
      exp_len_q <= '0;
      fill_q    <= '0;
      xor_q     <= '0;
      cmd_q     <= '0;
      limit_q   <= LimitReset;
    end else begin
      state_q   <= state_d;
      exp_len_q <= exp_len_d;
      fill_q    <= fill_d;
      xor_q     <= xor_d;
      cmd_q     <= cmd_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> (state_q == PsBody) && (fill_q < exp_len_q))
    else $error("payload write outside the frame body");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_len_q <= LenW'(MaxPayload))
    else $error("expected length exceeds the store depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.start |-> (fill_q == exp_len_q))
    else $error("frame handed over before the payload is complete");
`endif

endmodule

`default_nettype wire

// ===== rtl/msp_emit.sv =====
`default_nettype none

module msp_emit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire msp_pkg::emit_req_t        req_i,
  output logic      [msp_pkg::AddrW-1:0] raddr_o,
  input  wire logic [7:0]                rdata_i,
  output logic                           busy_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic      [7:0]                command_o,
  output logic      [6:0]                payload_length_o,
  output logic      [7:0]                data_byte_o,
  output logic      [5:0]                byte_index_o,
  output logic                           has_data_o,
  output logic                           last_o
);

  import msp_pkg::*;

  localparam logic [1:0] EsIdle  = 2'd0;
  localparam logic [1:0] EsRead  = 2'd1;
  localparam logic [1:0] EsLoad  = 2'd2;
  localparam logic [1:0] EsEmpty = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [LenW-1:0]  len_q;
  logic [ByteW-1:0] cmd_q;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;
  logic             load;
  logic             is_last;

  logic [ByteW-1:0] out_cmd_q;
  logic [LenW-1:0]  out_len_q;
  logic [ByteW-1:0] out_data_q;
  logic [AddrW-1:0] out_idx_q;
  logic             out_has_q;
  logic             out_last_q;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign is_last   = ({1'b0, idx_q} + LenW'(1)) == len_q;

  // Step through the stored payload, one read per payload byte; an empty frame gives one result without a read
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    load        = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      EsIdle: begin
        if (req_i.start) begin
          idx_d   = '0;
          state_d = (req_i.length == '0) ? EsEmpty : EsRead;
        end
      end
      EsRead: state_d = EsLoad;
      EsLoad: begin
        if (slot_free) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          if (is_last) begin
            state_d = EsIdle;
          end else begin
            idx_d   = idx_q + AddrW'(1);
            state_d = EsRead;
          end
        end
      end
      EsEmpty: begin
        if (slot_free) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = EsIdle;
        end
      end
      default: state_d = EsIdle;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EsIdle;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Latch the frame header and fill the output register
  always_ff @(posedge clk_i) begin
    if (req_i.start && (state_q == EsIdle)) begin
      len_q <= req_i.length;
      cmd_q <= req_i.command;
    end
    if (load) begin
      out_cmd_q  <= cmd_q;
      out_len_q  <= len_q;
      out_has_q  <= (state_q == EsLoad);
      out_data_q <= (state_q == EsLoad) ? rdata_i : '0;
      out_idx_q  <= (state_q == EsLoad) ? idx_q : '0;
      out_last_q <= (state_q == EsLoad) ? is_last : 1'b1;
    end
  end

  assign raddr_o          = idx_q;
  assign busy_o           = (state_q != EsIdle);
  assign out_valid_o      = out_valid_q;
  assign command_o        = out_cmd_q;
  assign payload_length_o = out_len_q;
  assign data_byte_o      = out_data_q;
  assign byte_index_o     = out_idx_q;
  assign has_data_o       = out_has_q;
  assign last_o           = out_last_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == EsIdle))
    else $error("frame handed over while a burst is still running");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EsRead) |=> (state_q == EsLoad))
    else $error("read data not taken in the cycle after the read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EsLoad) |-> ({1'b0, idx_q} < len_q))
    else $error("burst index beyond the frame length");
`endif

endmodule

`default_nettype wire

// ===== rtl/msp_v1_frame_receiver_top.sv =====
// Bytes are taken one per cycle while no burst is running; a header or payload
// byte has no result. A good checksum byte starts a burst: each payload byte is
// read from the store and then loaded into the output register; an empty frame
// gets a single result without data. The input is stalled while the burst runs,
// including every cycle that a full output register is held by the receiver.
// Reset clears the parser, the burst logic and the output valid flag and sets
// the size limit to 64; the payload buffer is not cleared.
`default_nettype none

module msp_v1_frame_receiver_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] command_o,
  output logic      [6:0] payload_length_o,
  output logic      [7:0] data_byte_o,
  output logic      [5:0] byte_index_o,
  output logic            has_data_o,
  output logic            last_o
);

  import msp_pkg::*;

  logic             accept;
  logic             busy;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic [ByteW-1:0] wdata;
  logic [ByteW-1:0] rdata;
  emit_req_t        req;

  // Stall the byte stream while a burst is running
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  msp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .req_o      (req)
  );

  msp_ram #(
    .Width (ByteW),
    .Depth (MaxPayload)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  msp_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .raddr_o          (raddr),
    .rdata_i          (rdata),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .command_o        (command_o),
    .payload_length_o (payload_length_o),
    .data_byte_o      (data_byte_o),
    .byte_index_o     (byte_index_o),
    .has_data_o       (has_data_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
